>>> rtl/core/dstt_pkg.sv
// Shared types and constants for the distance smoother to tone block.
// Holds field widths, register reset values, register indexes and the
// command and status structs between controller and datapath. No dependencies.
package dstt_pkg;

  localparam int WINDOW_DEF = 5;

  localparam int SMP_W  = 12;
  localparam int TONE_W = 16;
  localparam int DB_W   = 8;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 3;

  // Signed product of distance offset (13 bits) and tone span (17 bits).
  localparam int PROD_W = 30;
  // Magnitude of that product is at most 4095 * 65535 < 2**28.
  localparam int DIVD_W = 28;

  localparam logic [SMP_W-1:0]  DIST_LOW_RST  = 12'd0;
  localparam logic [SMP_W-1:0]  DIST_HIGH_RST = 12'd1000;
  localparam logic [TONE_W-1:0] TONE_LOW_RST  = 16'd100;
  localparam logic [TONE_W-1:0] TONE_HIGH_RST = 16'd800;
  localparam logic [DB_W-1:0]   DEADBAND_RST  = 8'd15;

  typedef enum logic [IDX_W-1:0] {
    REG_DIST_LOW  = 3'd0,
    REG_DIST_HIGH = 3'd1,
    REG_TONE_LOW  = 3'd2,
    REG_TONE_HIGH = 3'd3,
    REG_DEADBAND  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic avg_mul;
    logic avg_q;
    logic avg_fix;
    logic hold;
    logic map_mul;
    logic div_init;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/core/dstt_ctrl.sv
// Sequencing state machine for the distance smoother to tone block.
// Issues one command step per cycle unless output busy; uses dstt_pkg types.
module dstt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dstt_pkg::dp_stat_t stat,
  output dstt_pkg::dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_AVG_MUL  = 9'b000000010,
    S_AVG_Q    = 9'b000000100,
    S_AVG_FIX  = 9'b000001000,
    S_HOLD     = 9'b000010000,
    S_MAP_MUL  = 9'b000100000,
    S_DIV_INIT = 9'b001000000,
    S_DIV      = 9'b010000000,
    S_FIN      = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_AVG_MUL;
        end
      end
      S_AVG_MUL: begin
        cmd.avg_mul = 1'b1;
        state_next  = S_AVG_Q;
      end
      S_AVG_Q: begin
        cmd.avg_q  = 1'b1;
        state_next = S_AVG_FIX;
      end
      S_AVG_FIX: begin
        cmd.avg_fix = 1'b1;
        state_next  = S_HOLD;
      end
      S_HOLD: begin
        cmd.hold   = 1'b1;
        state_next = S_MAP_MUL;
      end
      S_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_next  = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // hold here while the previous result still waits downstream
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/dstt_dp.sv
// Datapath of the distance smoother to tone block: sample ring, running sum,
// reciprocal average, deadband hold, map multiply, shift-subtract divider,
// output register. Uses dstt_pkg.
module dstt_dp #(
  parameter int WINDOW = dstt_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dstt_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dstt_pkg::CFG_W-1:0]     cfg_data,
  input  logic [dstt_pkg::SMP_W-1:0]     distance_sample,
  input  dstt_pkg::dp_cmd_t              cmd,
  output dstt_pkg::dp_stat_t             stat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dstt_pkg::TONE_W-1:0]    tone_freq,
  output logic [dstt_pkg::SMP_W-1:0]     average_distance,
  output logic [dstt_pkg::SMP_W-1:0]     held_distance
);

  localparam int SMP_W  = dstt_pkg::SMP_W;
  localparam int TONE_W = dstt_pkg::TONE_W;
  localparam int DB_W   = dstt_pkg::DB_W;
  localparam int PROD_W = dstt_pkg::PROD_W;
  localparam int DIVD_W = dstt_pkg::DIVD_W;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = SMP_W + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(DIVD_W + 1);
  // floor(2**SUM_W / WINDOW): estimate is low by at most one
  localparam logic [SUM_W-1:0] RECIP = SUM_W'((1 << SUM_W) / WINDOW);

  // configuration
  logic [SMP_W-1:0]  dist_low, dist_high;
  logic [TONE_W-1:0] tone_low, tone_high;
  logic [DB_W-1:0]   deadband;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_low  <= dstt_pkg::DIST_LOW_RST;
      dist_high <= dstt_pkg::DIST_HIGH_RST;
      tone_low  <= dstt_pkg::TONE_LOW_RST;
      tone_high <= dstt_pkg::TONE_HIGH_RST;
      deadband  <= dstt_pkg::DEADBAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dstt_pkg::REG_DIST_LOW:  dist_low  <= cfg_data[SMP_W-1:0];
        dstt_pkg::REG_DIST_HIGH: dist_high <= cfg_data[SMP_W-1:0];
        dstt_pkg::REG_TONE_LOW:  tone_low  <= cfg_data[TONE_W-1:0];
        dstt_pkg::REG_TONE_HIGH: tone_high <= cfg_data[TONE_W-1:0];
        dstt_pkg::REG_DEADBAND:  deadband  <= cfg_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // sample ring and running sum
  logic [SMP_W-1:0]  ring [WINDOW];
  logic [SLOT_W-1:0] slot;
  logic [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
      slot <= '0;
      sum  <= '0;
    end else if (cmd.load) begin
      ring[slot] <= distance_sample;
      sum  <= sum - SUM_W'(ring[slot]) + SUM_W'(distance_sample);
      slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
    end
  end

  // average by reciprocal multiply and one correction
  logic [2*SUM_W-1:0] avg_prod;
  logic [SMP_W-1:0]   q_est;
  logic [SMP_W-1:0]   avg;
  logic [SUM_W-1:0]   q_times_w;
  logic [SUM_W-1:0]   avg_rem;

  assign q_times_w = {{(SUM_W-SMP_W){1'b0}}, q_est} * SUM_W'(WINDOW);
  assign avg_rem   = sum - q_times_w;

  always_ff @(posedge clk) begin
    if (cmd.avg_mul) begin
      avg_prod <= (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP);
    end
    if (cmd.avg_q) begin
      q_est <= avg_prod[SUM_W +: SMP_W];
    end
    if (cmd.avg_fix) begin
      avg <= (avg_rem >= SUM_W'(WINDOW)) ? q_est + SMP_W'(1) : q_est;
    end
  end

  // deadband hold
  logic [SMP_W-1:0] held;
  logic [SMP_W-1:0] diff;

  assign diff = (avg > held) ? avg - held : held - avg;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (cmd.hold && (diff > SMP_W'(deadband))) begin
      held <= avg;
    end
  end

  // linear map: (held - dist_low) * tone span / distance span
  logic signed [SMP_W:0]    offset;
  logic signed [TONE_W:0]   span_out;
  logic signed [SMP_W:0]    span_in;
  logic signed [PROD_W-1:0] map_prod;
  logic [PROD_W-1:0]        prod_mag;
  logic [SMP_W:0]           span_mag;

  assign offset   = $signed({1'b0, held}) - $signed({1'b0, dist_low});
  assign span_out = $signed({1'b0, tone_high}) - $signed({1'b0, tone_low});
  assign span_in  = $signed({1'b0, dist_high}) - $signed({1'b0, dist_low});
  assign prod_mag = map_prod[PROD_W-1] ? PROD_W'(-map_prod) : PROD_W'(map_prod);
  assign span_mag = span_in[SMP_W] ? (SMP_W+1)'(-span_in) : (SMP_W+1)'(span_in);

  always_ff @(posedge clk) begin
    if (cmd.map_mul) begin
      map_prod <= PROD_W'(offset) * PROD_W'(span_out);
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DIVD_W-1:0] quo;
  logic [SMP_W-1:0]  rem;
  logic [SMP_W-1:0]  dvs;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [SMP_W:0]    trial;
  logic              fits;

  assign trial = {rem, quo[DIVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_init) begin
      cnt <= CNT_W'(DIVD_W);
    end else if (cmd.div_step) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg <= map_prod[PROD_W-1] ^ span_in[SMP_W];
      quo <= prod_mag[DIVD_W-1:0];
      rem <= '0;
      dvs <= span_mag[SMP_W-1:0];
    end else if (cmd.div_step) begin
      rem <= fits ? SMP_W'(trial - {1'b0, dvs}) : trial[SMP_W-1:0];
      quo <= {quo[DIVD_W-2:0], fits};
    end
  end

  assign stat.div_last = (cnt == CNT_W'(1));
  assign stat.out_busy = out_valid && out_stall;

  // offset tone and saturate
  logic signed [PROD_W-1:0] q_signed;
  logic signed [PROD_W-1:0] tone_sum;
  logic [TONE_W-1:0]        tone_sat;

  assign q_signed = $signed({{(PROD_W-DIVD_W){1'b0}}, quo});
  assign tone_sum = (neg ? -q_signed : q_signed)
                  + $signed({{(PROD_W-TONE_W){1'b0}}, tone_low});

  always_comb begin
    priority if (span_in == '0) begin
      tone_sat = tone_low;
    end else if (tone_sum[PROD_W-1]) begin
      tone_sat = '0;
    end else if (|tone_sum[PROD_W-2:TONE_W]) begin
      tone_sat = '1;
    end else begin
      tone_sat = tone_sum[TONE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tone_freq        <= tone_sat;
      average_distance <= avg;
      held_distance    <= held;
    end
  end

endmodule

>>> rtl/core/distance_smoother_to_tone_top.sv
// Top level of the distance smoother to tone block.
// Joins the controller dstt_ctrl and the datapath dstt_dp; uses dstt_pkg.
//
// Each accepted distance sample enters a ring of WINDOW samples (cleared at
// reset, so early averages include zeros); the block returns the truncated
// mean of the ring, a held distance that follows the mean only when it moves
// by more than the deadband, and a tone frequency mapped linearly from the
// distance range onto the tone range, truncated toward zero and saturated to
// 0..65535 (tone_low when both distance ends are equal). One sample is in
// work at a time: the next sample is taken only after the result of the
// last one is loaded into the output register. The work of one sample is
// the 28-step shift-subtract divider of the map plus eight sequencing
// steps (ring update, reciprocal average in three steps, hold, map
// multiply, divider load, output load). A finished result waits in an
// output register, so the next sample is accepted while the previous
// result is still stalled; the block then holds in its final step until
// that register frees. Write configuration only while the block is idle.
module distance_smoother_to_tone_top #(
  parameter int WINDOW = dstt_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_we,
  input  logic [dstt_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dstt_pkg::CFG_W-1:0]  cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dstt_pkg::SMP_W-1:0]  distance_sample,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dstt_pkg::TONE_W-1:0] tone_freq,
  output logic [dstt_pkg::SMP_W-1:0]  average_distance,
  output logic [dstt_pkg::SMP_W-1:0]  held_distance
);

  dstt_pkg::dp_cmd_t  cmd;
  dstt_pkg::dp_stat_t stat;

  // sequence the steps of one transaction
  dstt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold the ring, arithmetic and output register
  dstt_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .distance_sample  (distance_sample),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .tone_freq        (tone_freq),
    .average_distance (average_distance),
    .held_distance    (held_distance)
  );

`ifndef SYNTHESIS
  // the ring updates exactly on an input transaction
  a_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) == cmd.load)
    else $error("ring update does not match input transaction");

  // one sample in work at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while a sample is in work");

  // never overwrite a result that is still stalled downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("pending result overwritten");
`endif

endmodule
